[rtl/spns_pkg.sv]
// ----------------------------------------------------------------------------
// spns_pkg
// Shared types and constants for the sparse plane nibble store.
// ----------------------------------------------------------------------------
package spns_pkg;

    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_WRITE    = 2'd1,
        OP_FILL     = 2'd2,
        OP_COMPRESS = 2'd3
    } t_op;

    // plane map entry codes: 0..127 slot number, then the two marks
    localparam logic [7:0] MARK_ZERO  = 8'd128;
    localparam logic [7:0] MARK_FULL  = 8'd129;
    localparam logic [7:0] SLOT_MAX   = 8'd128;
    localparam logic [7:0] SPARSE_LIM = 8'd127;
    localparam logic [7:0] BYTE_FULL  = 8'hff;
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [3:0] LVL_FULL   = 4'hf;
    localparam logic [3:0] LVL_ZERO   = 4'h0;
    localparam logic [6:0] BYTE_LAST  = 7'd127;

    // slot store address: bank, slot, byte within slot
    localparam int SLOT_AW = 15;

endpackage

[rtl/spns_ram.sv]
// ----------------------------------------------------------------------------
// spns_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module spns_ram #(
    parameter int DW = 8,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/sparse_plane_nibble_store.sv]
// ----------------------------------------------------------------------------
// sparse_plane_nibble_store
// Volume of 4-bit levels, HEIGHT planes of 16x16 cells, sparse by plane.
//
// Input channel (i_valid/o_ready) takes one command word: read, write, fill
// or compress. Output channel (o_valid/i_ready) returns one word per command
// with the level read, the allocated slot count and the sparse flag.
// Commands run one at a time. A fill, or a plane out of range, goes
// straight to the result. Reads and writes start with a registered plane
// map lookup. A read of a marked plane takes its level from the mark; of
// a mapped plane it reads the slot byte. A write into a mapped plane is a
// read-modify-write of the slot byte store; a write that allocates a slot
// prefills it byte per cycle. Compress scans each mapped plane's slot
// byte per cycle through that store's single read port.
// Compress copies kept slots into the other half of a double-banked store
// and map, then swaps banks only if some slot was demoted.
// Reset marks every plane uniform 0 at once (valid bits on the map) and
// frees all slots; the store itself is not cleared. A new command is taken
// while the previous result still waits; when the receiver stalls, the
// finished result of the next command waits in the block until taken.
// ----------------------------------------------------------------------------
module sparse_plane_nibble_store #(
    parameter int HEIGHT = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [3:0] i_col_x,
    input  logic [6:0] i_height,
    input  logic [3:0] i_col_z,
    input  logic [3:0] i_level,
    input  logic       i_fill_bright,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_read_level,
    output logic [7:0] o_slots_used,
    output logic       o_is_sparse
);

    localparam int          YW     = $clog2(HEIGHT);
    localparam int          MAW    = YW + 1;
    localparam logic [7:0]  HLIM   = 8'(HEIGHT);
    localparam logic [6:0]  Y_LAST = 7'(HEIGHT - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP,
        S_RD_DATA,
        S_WR_DATA,
        S_PREFILL,
        S_C_ISSUE,
        S_C_MAP,
        S_C_SCAN,
        S_C_END,
        S_FINISH
    } t_state;

    t_state            r_state;
    spns_pkg::t_op     r_op;
    logic [3:0]        r_x;
    logic [6:0]        r_y;
    logic [3:0]        r_z;
    logic [3:0]        r_lvl;
    logic [6:0]        r_e;
    logic [7:0]        r_pf;
    logic [7:0]        r_j;
    logic [6:0]        r_jd;
    logic              r_rdv;
    logic              r_all0;
    logic              r_all15;
    logic [7:0]        r_used;
    logic              r_dem;
    logic              r_bank;
    logic              r_fill_full;
    logic [1:0][HEIGHT-1:0] r_vld;
    logic [7:0]        r_count;
    logic [3:0]        r_rd;
    logic              r_o_valid;
    logic [3:0]        r_o_lvl;
    logic [7:0]        r_o_used;
    logic              r_o_sparse;

    logic              acc;
    logic [YW-1:0]     yi;
    logic [7:0]        fill_mark;
    logic [7:0]        e_cur;
    logic              e_mark;
    logic [3:0]        e_lvl;
    logic              need_alloc;
    logic [6:0]        cell_byte;
    logic [7:0]        map_rd;
    logic              map_we;
    logic [MAW-1:0]    map_waddr;
    logic [7:0]        map_wdata;
    logic [MAW-1:0]    map_raddr;
    logic [7:0]        slot_rd;
    logic              slot_we;
    logic [spns_pkg::SLOT_AW-1:0] slot_waddr;
    logic [7:0]        slot_wdata;
    logic [spns_pkg::SLOT_AW-1:0] slot_raddr;
    logic              b0;
    logic              b15;
    logic              scan_last;
    logic [7:0]        scan_entry;
    logic [3:0]        nib;
    logic [7:0]        merged;

    assign acc       = i_valid && o_ready;
    assign yi        = r_y[YW-1:0];
    assign fill_mark = r_fill_full ? spns_pkg::MARK_FULL : spns_pkg::MARK_ZERO;
    assign e_cur     = r_vld[r_bank][yi] ? map_rd : fill_mark;
    assign e_mark    = e_cur[7];
    assign e_lvl     = (e_cur == spns_pkg::MARK_FULL) ? spns_pkg::LVL_FULL
                                                      : spns_pkg::LVL_ZERO;
    assign need_alloc = (r_lvl != e_lvl) && (r_count < spns_pkg::SLOT_MAX);
    assign cell_byte = {r_x, r_z[3:1]};

    assign b0        = r_all0 && (slot_rd == spns_pkg::BYTE_ZERO);
    assign b15       = r_all15 && (slot_rd == spns_pkg::BYTE_FULL);
    assign scan_last = r_rdv && (r_jd == spns_pkg::BYTE_LAST);
    assign scan_entry = b0  ? spns_pkg::MARK_ZERO :
                        b15 ? spns_pkg::MARK_FULL : r_used;

    assign nib    = r_z[0] ? slot_rd[7:4] : slot_rd[3:0];
    // byte under write: stored byte on a mapped plane, prefill otherwise
    always_comb begin
        logic [7:0] base;
        base = (r_state == S_PREFILL) ? r_pf : slot_rd;
        merged = r_z[0] ? {r_lvl, base[3:0]} : {base[7:4], r_lvl};
    end

    // memory port steering
    always_comb begin
        map_raddr = (r_state == S_IDLE) ? {r_bank, i_height[YW-1:0]} : {r_bank, yi};
        map_we    = 1'b0;
        map_waddr = {~r_bank, yi};
        map_wdata = e_cur;
        case (r_state)
            S_MAP: begin
                if (r_op == spns_pkg::OP_WRITE && e_mark && need_alloc) begin
                    map_we    = 1'b1;
                    map_waddr = {r_bank, yi};
                    map_wdata = r_count;
                end
            end
            S_C_MAP: begin
                map_we = e_mark;
            end
            S_C_SCAN: begin
                map_we    = scan_last;
                map_wdata = scan_entry;
            end
            default: ;
        endcase
    end

    always_comb begin
        slot_raddr = {r_bank, r_e, r_j[6:0]};
        slot_we    = 1'b0;
        slot_waddr = {r_bank, r_e, cell_byte};
        slot_wdata = merged;
        case (r_state)
            S_MAP: slot_raddr = {r_bank, e_cur[6:0], cell_byte};
            S_WR_DATA: slot_we = 1'b1;
            S_PREFILL: begin
                slot_we    = 1'b1;
                slot_waddr = {r_bank, r_e, r_j[6:0]};
                slot_wdata = (r_j[6:0] == cell_byte) ? merged : r_pf;
            end
            S_C_SCAN: begin
                slot_we    = r_rdv;
                slot_waddr = {~r_bank, r_used[6:0], r_jd};
                slot_wdata = slot_rd;
            end
            default: ;
        endcase
    end

    spns_ram #(.DW(8), .AW(MAW)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rd)
    );

    spns_ram #(.DW(8), .AW(spns_pkg::SLOT_AW)) u_slots (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bank      <= 1'b0;
            r_fill_full <= 1'b0;
            r_vld       <= '0;
            r_count     <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            // S_FINISH handles the output register itself
            if (r_o_valid && i_ready && r_state != S_FINISH) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_op  <= spns_pkg::t_op'(i_op);
                        r_x   <= i_col_x;
                        r_z   <= i_col_z;
                        r_lvl <= i_level;
                        r_rd  <= '0;
                        case (spns_pkg::t_op'(i_op))
                            spns_pkg::OP_FILL: begin
                                r_vld       <= '0;
                                r_fill_full <= i_fill_bright;
                                r_count     <= '0;
                                r_state     <= S_FINISH;
                            end
                            spns_pkg::OP_COMPRESS: begin
                                r_y     <= '0;
                                r_used  <= '0;
                                r_dem   <= 1'b0;
                                r_state <= S_C_ISSUE;
                            end
                            default: begin
                                r_y     <= i_height;
                                r_state <= ({1'b0, i_height} < HLIM) ? S_MAP : S_FINISH;
                            end
                        endcase
                    end
                end
                S_MAP: begin
                    if (r_op == spns_pkg::OP_READ) begin
                        if (e_mark) begin
                            r_rd    <= e_lvl;
                            r_state <= S_FINISH;
                        end else begin
                            r_state <= S_RD_DATA;
                        end
                    end else if (!e_mark) begin
                        r_e     <= e_cur[6:0];
                        r_state <= S_WR_DATA;
                    end else if (need_alloc) begin
                        r_e              <= r_count[6:0];
                        r_pf             <= (e_lvl == spns_pkg::LVL_FULL) ?
                                            spns_pkg::BYTE_FULL : spns_pkg::BYTE_ZERO;
                        r_j              <= '0;
                        r_vld[r_bank][yi] <= 1'b1;
                        r_count          <= r_count + 8'd1;
                        r_state          <= S_PREFILL;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end
                S_RD_DATA: begin
                    r_rd    <= nib;
                    r_state <= S_FINISH;
                end
                S_WR_DATA: begin
                    r_state <= S_FINISH;
                end
                S_PREFILL: begin
                    r_j <= r_j + 8'd1;
                    if (r_j[6:0] == spns_pkg::BYTE_LAST) begin
                        r_state <= S_FINISH;
                    end
                end
                S_C_ISSUE: begin
                    r_state <= S_C_MAP;
                end
                S_C_MAP: begin
                    if (e_mark) begin
                        r_vld[~r_bank][yi] <= 1'b1;
                        if (r_y == Y_LAST) begin
                            r_state <= S_C_END;
                        end else begin
                            r_y     <= r_y + 7'd1;
                            r_state <= S_C_ISSUE;
                        end
                    end else begin
                        r_e     <= e_cur[6:0];
                        r_j     <= '0;
                        r_rdv   <= 1'b0;
                        r_all0  <= 1'b1;
                        r_all15 <= 1'b1;
                        r_state <= S_C_SCAN;
                    end
                end
                S_C_SCAN: begin
                    r_rdv <= !r_j[7];
                    r_jd  <= r_j[6:0];
                    if (!r_j[7]) begin
                        r_j <= r_j + 8'd1;
                    end
                    if (r_rdv) begin
                        r_all0  <= b0;
                        r_all15 <= b15;
                    end
                    if (scan_last) begin
                        r_vld[~r_bank][yi] <= 1'b1;
                        if (b0 || b15) begin
                            r_dem <= 1'b1;
                        end else begin
                            r_used <= r_used + 8'd1;
                        end
                        if (r_y == Y_LAST) begin
                            r_state <= S_C_END;
                        end else begin
                            r_y     <= r_y + 7'd1;
                            r_state <= S_C_ISSUE;
                        end
                    end
                end
                S_C_END: begin
                    if (r_dem) begin
                        r_bank  <= ~r_bank;
                        r_count <= r_used;
                    end
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_lvl    <= r_rd;
                        r_o_used   <= r_count;
                        r_o_sparse <= (r_count < spns_pkg::SPARSE_LIM);
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_read_level = r_o_lvl;
    assign o_slots_used = r_o_used;
    assign o_is_sparse  = r_o_sparse;

endmodule
